/* rtl/crld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crld_pkg: shared types and constants
// Widths, command codes, result kinds and controller/datapath struct types.
// ----------------------------------------------------------------------------
package crld_pkg;

  localparam int QueueDepth = 64;
  localparam int NodeCount  = 64;
  localparam int QW         = $clog2(QueueDepth);
  localparam int NW         = $clog2(NodeCount);
  localparam int CW         = $clog2(QueueDepth + 1);

  localparam logic [2:0] CMD_ENQ   = 3'd0;
  localparam logic [2:0] CMD_SVC   = 3'd1;
  localparam logic [2:0] CMD_DONE  = 3'd2;
  localparam logic [2:0] CMD_BUMP  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] KIND_DISP = 2'd0;
  localparam logic [1:0] KIND_PASS = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;
  localparam logic [1:0] KIND_REJ  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ATTR_UNI   = 2'd1;
  localparam logic [1:0] ATTR_MULTI = 2'd2;

  localparam logic [1:0] REG_GLIMIT = 2'd0;
  localparam logic [1:0] REG_NLIMIT = 2'd1;
  localparam logic [1:0] REG_QEN    = 2'd2;
  localparam logic [1:0] REG_CHKMC  = 2'd3;

  typedef enum logic [7:0] {
    S_CLR   = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_EXEC  = 8'b00000100,
    S_RD    = 8'b00001000,
    S_NRD   = 8'b00010000,
    S_CHK   = 8'b00100000,
    S_SVEND = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;       // clear one node counter after reset
    logic latch;     // capture the input transaction
    logic exec;      // run a single-step command
    logic rd;        // issue queue read at read pointer
    logic nrd;       // read node counter of the fetched entry
    logic chk;       // evaluate one fetched entry
    logic svend;     // close the walk
    logic fin;       // drive final result of the walk
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // last node counter being cleared
    logic svc_go;    // service walk must run
    logic walk_more; // more entries to read
  } dp_stat_t;

endpackage

/* rtl/crld_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crld_ctrl: sequencing controller
// Runs the counter clear, single-step commands and the service walk.
// ----------------------------------------------------------------------------
module crld_ctrl import crld_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = stat.svc_go ? S_RD : S_IDLE;
      end
      S_RD: begin
        if (stat.walk_more) begin
          cmd.rd = 1'b1;
          state_nxt = S_NRD;
        end else begin
          state_nxt = S_SVEND;
        end
      end
      S_NRD: begin
        cmd.nrd = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        state_nxt = S_RD;
      end
      S_SVEND: begin
        cmd.svend = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* rtl/crld_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crld_dp: queue, counters and result datapath
// Queue memory with compacting walk, node counter memory, result register.
// ----------------------------------------------------------------------------
module crld_dp import crld_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_req_tag,
  input  logic [5:0]  in_node_id,
  input  logic [7:0]  in_req_pass,
  input  logic        in_abandon,
  input  logic [1:0]  in_done_status,
  input  logic        in_reply_bad,
  input  logic [1:0]  in_attr_kind,
  input  logic [10:0] glimit,
  input  logic [7:0]  nlimit,
  input  logic        qen,
  input  logic        chkmc,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_tag,
  output logic [5:0]  out_out_node,
  output logic        out_resweep_unicast,
  output logic        out_resweep_multicast,
  output logic        out_timeout_seen,
  output logic        out_drained,
  output logic        out_last
);

  // latched transaction
  logic [2:0]  cmd_r;
  logic [7:0]  tag_r, rpass_r;
  logic [5:0]  node_r;
  logic        aband_r, bad_r;
  logic [1:0]  st_r, attr_r;

  // state
  logic [CW-1:0] count_r, count_nxt;
  logic [10:0]   tot_r, tot_nxt;
  logic [7:0]    cpass_r;

  // node counter memory, cleared one entry per cycle after reset
  logic [7:0]    nmem [NodeCount];
  logic [7:0]    nrd_r;
  logic          nre, nwe;
  logic [NW-1:0] nra, nwa, clp_r;
  logic [7:0]    nwd;

  // queue memory: 8+6+8 bits per entry
  logic [21:0]   qmem [QueueDepth];
  logic [21:0]   qrd_r;
  logic          qwe;
  logic [QW-1:0] qwa;
  logic [21:0]   qwd;

  // walk
  logic [CW-1:0] rp_r, wp_r;
  logic [CW:0]   nsent_r;   // results sent this walk
  logic          have_r;    // a dispatch is held back
  logic [7:0]    htag_r;    // held dispatch
  logic [5:0]    hnode_r;

  // result register
  logic       v_r, last_r, dr_r, ru_r, rm_r, to_r;
  logic [1:0] kind_r;
  logic [7:0] otag_r;
  logic [5:0] onode_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_cmd; tag_r <= in_req_tag; node_r <= in_node_id;
      rpass_r <= in_req_pass; aband_r <= in_abandon; st_r <= in_done_status;
      bad_r <= in_reply_bad; attr_r <= in_attr_kind;
    end
  end

  assign stat.svc_go = (cmd_r == CMD_SVC) && (count_r != '0) && !aband_r &&
                       (tot_r < glimit);
  assign stat.walk_more = (rp_r < count_r);
  assign stat.clr_last  = (clp_r == NW'(NodeCount - 1));

  // entry evaluation
  logic [7:0]  e_tag, e_pass;
  logic [5:0]  e_node;
  logic [NW-1:0] e_idx;
  logic        e_same, e_can;
  assign {e_tag, e_node, e_pass} = qrd_r;
  assign e_idx  = NW'(e_node);
  assign e_same = (e_pass == cpass_r);
  assign e_can  = (tot_r < glimit) && (nsent_r < (CW+1)'(QueueDepth)) &&
                  (!e_same || (nrd_r < nlimit));

  // completion decode
  logic c_same, c_to, c_fail;
  logic [NW-1:0] c_idx;
  assign c_same = (rpass_r == cpass_r);
  assign c_to   = (st_r == ST_TIMEOUT);
  assign c_fail = c_to || ((st_r == ST_OK) && bad_r);
  assign c_idx  = NW'(node_r);

  // counter read: completion node at latch, entry node during the walk
  assign nre = cmd.latch || cmd.nrd;
  assign nra = cmd.latch ? NW'(in_node_id) : e_idx;

  always_comb begin
    count_nxt = count_r;
    tot_nxt   = tot_r;
    qwe = 1'b0; qwa = '0; qwd = '0;
    nwe = 1'b0; nwa = '0; nwd = '0;
    if (cmd.clr) begin
      nwe = 1'b1; nwa = clp_r;
    end
    if (cmd.exec) begin
      case (cmd_r)
        CMD_ENQ: if (qen && (count_r < CW'(QueueDepth))) begin
          qwe = 1'b1; qwa = count_r[QW-1:0]; qwd = {tag_r, node_r, cpass_r};
          count_nxt = count_r + 1'b1;
        end
        CMD_SVC:   if (count_r != '0 && aband_r) count_nxt = '0;
        CMD_DONE: begin
          if (tot_r != '0) tot_nxt = tot_r - 1'b1;
          if (c_same && nrd_r != '0) begin
            nwe = 1'b1; nwa = c_idx; nwd = nrd_r - 1'b1;
          end
        end
        CMD_CLEAR: count_nxt = '0;
        default: ;
      endcase
    end
    if (cmd.chk) begin
      if (e_can) begin
        tot_nxt = tot_r + 1'b1;
        if (e_same && nrd_r != 8'hFF) begin
          nwe = 1'b1; nwa = e_idx; nwd = nrd_r + 1'b1;
        end
      end else begin
        qwe = 1'b1; qwa = wp_r[QW-1:0]; qwd = qrd_r;
      end
    end
    if (cmd.svend) count_nxt = wp_r;
  end

  always_ff @(posedge clk) begin
    if (qwe) qmem[qwa] <= qwd;
    if (cmd.rd) qrd_r <= qmem[rp_r[QW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nwe) nmem[nwa] <= nwd;
    if (nre) nrd_r <= nmem[nra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; tot_r <= '0; cpass_r <= '0;
      rp_r <= '0; wp_r <= '0; nsent_r <= '0; have_r <= 1'b0;
      v_r <= 1'b0; clp_r <= '0;
    end else begin
      count_r <= count_nxt;
      tot_r   <= tot_nxt;
      v_r     <= 1'b0;
      if (cmd.clr) clp_r <= clp_r + 1'b1;
      if (cmd.exec) begin
        rp_r <= '0; wp_r <= '0; nsent_r <= '0; have_r <= 1'b0;
        if (cmd_r == CMD_BUMP) cpass_r <= cpass_r + 1'b1;
        if (!stat.svc_go) v_r <= 1'b1;
      end
      if (cmd.rd) rp_r <= rp_r + 1'b1;
      if (cmd.chk) begin
        if (e_can) begin
          nsent_r <= nsent_r + 1'b1;
          // the held dispatch goes out; this one waits since last is unknown
          if (have_r) v_r <= 1'b1;
          have_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end
      if (cmd.fin) v_r <= 1'b1;
    end
  end

  // result payload; drained computed from the post-step state
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      last_r <= 1'b1; ru_r <= 1'b0; rm_r <= 1'b0; to_r <= 1'b0;
      otag_r <= '0; onode_r <= '0; kind_r <= KIND_ACK;
      dr_r <= (count_nxt == '0) && (tot_nxt == '0);
      case (cmd_r)
        CMD_ENQ: begin
          otag_r <= tag_r; onode_r <= node_r;
          if (!qen) kind_r <= KIND_PASS;
          else if (count_r >= CW'(QueueDepth)) kind_r <= KIND_REJ;
        end
        CMD_DONE: begin
          to_r <= c_to;
          ru_r <= (attr_r == ATTR_UNI) && c_fail;
          rm_r <= (attr_r == ATTR_MULTI) && chkmc && c_fail;
        end
        default: ;
      endcase
    end
    if (cmd.chk && e_can) begin
      htag_r <= e_tag; hnode_r <= e_node;
      if (have_r) begin
        kind_r <= KIND_DISP; otag_r <= htag_r; onode_r <= hnode_r;
        last_r <= 1'b0;
      end
    end
    if (cmd.svend) dr_r <= (wp_r == '0) && (tot_r == '0);
    if (cmd.fin) begin
      last_r <= 1'b1;
      if (have_r) begin
        kind_r <= KIND_DISP; otag_r <= htag_r; onode_r <= hnode_r;
      end else begin
        kind_r <= KIND_ACK; otag_r <= '0; onode_r <= '0;
      end
    end
  end

  // drained is exact only on the final result; earlier dispatches carry 0,
  // which holds since a dispatch leaves total_outstanding nonzero.
  assign out_valid             = v_r;
  assign out_kind              = kind_r;
  assign out_out_tag           = otag_r;
  assign out_out_node          = onode_r;
  assign out_resweep_unicast   = ru_r;
  assign out_resweep_multicast = rm_r;
  assign out_timeout_seen      = to_r;
  assign out_drained           = dr_r & last_r;
  assign out_last              = last_r;

endmodule

/* rtl/credit_limited_request_dispatcher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_limited_request_dispatcher_top
// Queue of pending requests dispatched under global and per-node credits.
// ----------------------------------------------------------------------------
// Usage: raise start with the command fields while busy is low; the
// transaction is taken at that edge. After reset the block clears its 64
// per-node credit counters, one per cycle, and holds busy high until the
// last one is cleared. Results appear on the out_ ports for one cycle
// each, flagged by out_valid; the receiver cannot stall, so it must take
// every strobe. out_last marks the final result of a transaction.
// Enqueue, completion, bump, clear and a service that does not walk the
// queue put their single result on the ports once the execute step has
// registered it, with busy already low, so the next command can be
// accepted while that result is shown. A service that walks the queue
// handles each entry in turn (read the entry, read its node counter,
// decide) between the execute step and the close of the walk. Each
// dispatch is held back until the next one is found, so the last one
// closes the walk. The user must write registers over the APB port only
// while busy is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module credit_limited_request_dispatcher_top import crld_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_req_tag,
  input  logic [5:0]  in_node_id,
  input  logic [7:0]  in_req_pass,
  input  logic        in_abandon,
  input  logic [1:0]  in_done_status,
  input  logic        in_reply_bad,
  input  logic [1:0]  in_attr_kind,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_tag,
  output logic [5:0]  out_out_node,
  output logic        out_resweep_unicast,
  output logic        out_resweep_multicast,
  output logic        out_timeout_seen,
  output logic        out_drained,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [10:0] glimit_r;
  logic [7:0]  nlimit_r;
  logic        qen_r, chkmc_r;
  logic [1:0]  ridx;
  logic        wr_en, addr_ok;

  assign cfg_pready = 1'b1;
  assign ridx    = cfg_paddr[3:2];
  assign addr_ok = (cfg_paddr[1:0] == 2'b00);
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite && addr_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glimit_r <= 11'd16; nlimit_r <= 8'd4; qen_r <= 1'b1; chkmc_r <= 1'b0;
    end else if (wr_en) begin
      unique case (ridx)
        REG_GLIMIT: glimit_r <= cfg_pwdata[10:0];
        REG_NLIMIT: nlimit_r <= cfg_pwdata[7:0];
        REG_QEN:    qen_r    <= cfg_pwdata[0];
        REG_CHKMC:  chkmc_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (addr_ok) begin
      unique case (ridx)
        REG_GLIMIT: cfg_prdata = {21'd0, glimit_r};
        REG_NLIMIT: cfg_prdata = {24'd0, nlimit_r};
        REG_QEN:    cfg_prdata = {31'd0, qen_r};
        REG_CHKMC:  cfg_prdata = {31'd0, chkmc_r};
        default: ;
      endcase
    end
  end

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  crld_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(dstat), .cmd(dcmd), .busy(busy)
  );

  crld_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(dcmd), .stat(dstat),
    .in_cmd(in_cmd), .in_req_tag(in_req_tag), .in_node_id(in_node_id),
    .in_req_pass(in_req_pass), .in_abandon(in_abandon),
    .in_done_status(in_done_status), .in_reply_bad(in_reply_bad),
    .in_attr_kind(in_attr_kind),
    .glimit(glimit_r), .nlimit(nlimit_r), .qen(qen_r), .chkmc(chkmc_r),
    .out_valid(out_valid), .out_kind(out_kind), .out_out_tag(out_out_tag),
    .out_out_node(out_out_node), .out_resweep_unicast(out_resweep_unicast),
    .out_resweep_multicast(out_resweep_multicast),
    .out_timeout_seen(out_timeout_seen), .out_drained(out_drained),
    .out_last(out_last)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher testbench
// Directed table then constrained-by-hand random commands; every result is
// checked field by field against an in-bench model of queue and credits.
// ----------------------------------------------------------------------------
module testbench;
  import crld_pkg::*;

  // one expected/observed result
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tag;
    logic [5:0] node;
    logic       ru;
    logic       rm;
    logic       to;
    logic       drained;
    logic       last;
  } res_t;

  // one command transaction
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tag;
    logic [5:0] node;
    logic [7:0] rpass;
    logic       aband;
    logic [1:0] st;
    logic       bad;
    logic [1:0] attr;
  } cmd_t;

  // directed row: command plus optional typed-in last result
  typedef struct packed {
    cmd_t       c;
    logic       has_exp;
    res_t       r;
  } row_t;

  logic clk, rst_n, start, busy;
  logic [2:0] in_cmd;
  logic [7:0] in_req_tag, in_req_pass;
  logic [5:0] in_node_id;
  logic in_abandon, in_reply_bad;
  logic [1:0] in_done_status, in_attr_kind;
  logic out_valid, out_resweep_unicast, out_resweep_multicast, out_timeout_seen;
  logic out_drained, out_last;
  logic [1:0] out_kind;
  logic [7:0] out_out_tag;
  logic [5:0] out_out_node;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  credit_limited_request_dispatcher_top i_dut (.*);

  // predictor state
  logic [10:0] m_glimit;
  logic [7:0]  m_nlimit;
  logic        m_qen, m_chkmc;
  logic [7:0]  q_tag [$];
  logic [5:0]  q_node [$];
  logic [7:0]  q_pass [$];
  logic [10:0] m_total;
  logic [7:0]  m_node_cnt [64];
  logic [7:0]  m_pass;

  res_t expected_results [$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_disp = 0;
  int idle_pct = 26;
  int stall_cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Push the results one command produces and advance the model.
  task automatic predict_command(input cmd_t c);
    res_t r [$];
    res_t x;
    logic [7:0] kt [$];
    logic [5:0] kn [$];
    logic [7:0] kp [$];
    logic same, to, fail, dr;
    begin
      x = '0;
      case (c.cmd)
        CMD_ENQ: begin
          x.tag = c.tag; x.node = c.node;
          if (!m_qen) x.kind = KIND_PASS;
          else if (q_tag.size() >= 64) x.kind = KIND_REJ;
          else begin
            q_tag.push_back(c.tag); q_node.push_back(c.node); q_pass.push_back(m_pass);
            x.kind = KIND_ACK;
          end
          r.push_back(x);
        end
        CMD_SVC: begin
          if (q_tag.size() != 0 && c.aband) begin
            q_tag = {}; q_node = {}; q_pass = {};
          end else if (q_tag.size() != 0 && m_total < m_glimit) begin
            foreach (q_tag[i]) begin
              same = (q_pass[i] == m_pass);
              if (m_total < m_glimit && r.size() < 64 &&
                  (!same || m_node_cnt[q_node[i]] < m_nlimit)) begin
                m_total++;
                if (same && m_node_cnt[q_node[i]] < 8'd255) m_node_cnt[q_node[i]]++;
                x = '0; x.kind = KIND_DISP; x.tag = q_tag[i]; x.node = q_node[i];
                r.push_back(x);
                n_disp++;
              end else begin
                kt.push_back(q_tag[i]); kn.push_back(q_node[i]); kp.push_back(q_pass[i]);
              end
            end
            q_tag = kt; q_node = kn; q_pass = kp;
          end
          if (r.size() == 0) begin
            x = '0; x.kind = KIND_ACK; r.push_back(x);
          end
        end
        CMD_DONE: begin
          to = (c.st == ST_TIMEOUT);
          fail = to || (c.st == ST_OK && c.bad);
          if (m_total != 0) m_total--;
          if (c.rpass == m_pass && m_node_cnt[c.node] != 0) m_node_cnt[c.node]--;
          x.kind = KIND_ACK;
          x.ru = (c.attr == ATTR_UNI) && fail;
          x.rm = (c.attr == ATTR_MULTI) && m_chkmc && fail;
          x.to = to;
          r.push_back(x);
        end
        default: begin
          if (c.cmd == CMD_BUMP) m_pass++;
          else if (c.cmd == CMD_CLEAR) begin
            q_tag = {}; q_node = {}; q_pass = {};
          end
          x.kind = KIND_ACK; r.push_back(x);
        end
      endcase
      dr = (q_tag.size() == 0) && (m_total == 0);
      foreach (r[i]) begin
        r[i].drained = dr;
        r[i].last = (i == r.size() - 1);
        expected_results.push_back(r[i]);
      end
    end
  endtask

  // Result monitor: the block strobes results, so every strobe is taken.
  always @(posedge clk) begin
    res_t act, want;
    if (rst_n && out_valid) begin
      act = {out_kind, out_out_tag, out_out_node, out_resweep_unicast,
             out_resweep_multicast, out_timeout_seen, out_drained, out_last};
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, act);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (act !== want) begin
          $display("%0t: result mismatch, expected %h, actual %h", $time, want, act);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_psel && cfg_penable)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Register write, only with the block idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    begin
      @(posedge clk);
      cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
      cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
      @(posedge clk);
      cfg_penable <= 1;
      @(posedge clk);
      cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
      case (idx)
        REG_GLIMIT: m_glimit = val[10:0];
        REG_NLIMIT: m_nlimit = val[7:0];
        REG_QEN:    m_qen = val[0];
        default:    m_chkmc = val[0];
      endcase
    end
  endtask

  // Wait for all results, then let the walk's tail settle.
  task automatic wait_quiet();
    begin
      while (expected_results.size() != 0) @(posedge clk);
      repeat (80) @(posedge clk);
    end
  endtask

  // Present one command; held until accepted. The first edge wait keeps
  // the drop of start from the previous command in its own time step.
  task automatic issue_command(input cmd_t c);
    begin
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
      start <= 1;
      {in_cmd, in_req_tag, in_node_id, in_req_pass, in_abandon, in_done_status,
       in_reply_bad, in_attr_kind} <= c;
      @(posedge clk);
      while (busy) @(posedge clk);
      predict_command(c);
      n_items++;
      start <= 0;
    end
  endtask

  function automatic cmd_t random_command();
    cmd_t c;
    int p;
    begin
      c = cmd_t'(31'($urandom));
      p = $urandom_range(99);
      // mostly enqueues and services so the queue fills and drains
      if (p < 40) c.cmd = CMD_ENQ;
      else if (p < 60) c.cmd = CMD_SVC;
      else if (p < 88) c.cmd = CMD_DONE;
      else if (p < 93) c.cmd = CMD_BUMP;
      else if (p < 96) c.cmd = CMD_CLEAR;
      else c.cmd = 3'($urandom_range(7));
      if (c.cmd == CMD_SVC) c.aband = ($urandom_range(19) == 0);
      if (c.cmd == CMD_DONE && $urandom_range(3) != 0) c.rpass = m_pass;
      c.node = 6'($urandom_range(7)) | ($urandom_range(9) == 0 ? 6'($urandom) : 6'd0);
      return c;
    end
  endfunction

  row_t dir_rows [$];

  // Compact row builder for the directed table.
  function automatic row_t mk(input logic [2:0] cmd, input logic [7:0] tag,
                              input logic [5:0] node, input logic [7:0] rp,
                              input logic ab, input logic [1:0] st,
                              input logic bad, input logic [1:0] at,
                              input logic he, input res_t r);
    row_t w;
    begin
      w.c = {cmd, tag, node, rp, ab, st, bad, at};
      w.has_exp = he; w.r = r;
      return w;
    end
  endfunction

  initial begin
    cmd_t c;
    res_t nr;
    rst_n = 0; start = 0;
    {in_cmd, in_req_tag, in_node_id, in_req_pass, in_abandon, in_done_status,
     in_reply_bad, in_attr_kind} = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    m_glimit = 16; m_nlimit = 4; m_qen = 1; m_chkmc = 0;
    m_total = 0; m_pass = 0;
    foreach (m_node_cnt[i]) m_node_cnt[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed table: {kind,tag,node,ru,rm,to,drained,last} where typed in.
    nr = '0;
    dir_rows.push_back(mk(CMD_SVC, 0, 0, 0, 0, 0, 0, 0, 1,
                          {KIND_ACK, 8'd0, 6'd0, 3'b000, 1'b1, 1'b1}));   // empty service
    dir_rows.push_back(mk(CMD_DONE, 0, 0, 0, 0, ST_TIMEOUT, 0, ATTR_UNI, 1,
                          {KIND_ACK, 8'd0, 6'd0, 3'b101, 1'b1, 1'b1}));   // timeout, floor
    dir_rows.push_back(mk(CMD_ENQ, 8'hFF, 6'h3F, 0, 0, 0, 0, 0, 1,
                          {KIND_ACK, 8'hFF, 6'h3F, 3'b000, 1'b0, 1'b1}));
    dir_rows.push_back(mk(CMD_ENQ, 8'h00, 6'h00, 0, 0, 0, 0, 0, 0, nr));
    dir_rows.push_back(mk(CMD_ENQ, 8'hA5, 6'h3F, 0, 0, 0, 0, 0, 0, nr));
    dir_rows.push_back(mk(CMD_SVC, 0, 0, 0, 0, 0, 0, 0, 0, nr));
    dir_rows.push_back(mk(CMD_DONE, 0, 6'h3F, 0, 0, ST_OK, 1, ATTR_UNI, 1,
                          {KIND_ACK, 8'd0, 6'd0, 3'b100, 1'b0, 1'b1}));
    dir_rows.push_back(mk(CMD_DONE, 0, 6'h3F, 0, 0, ST_OK, 1, ATTR_MULTI, 0, nr));
    dir_rows.push_back(mk(CMD_DONE, 0, 0, 8'hFF, 0, 2'd2, 1, ATTR_UNI, 0, nr));
    dir_rows.push_back(mk(CMD_DONE, 0, 0, 0, 0, 2'd3, 1, 2'd3, 0, nr));
    dir_rows.push_back(mk(CMD_ENQ, 8'h11, 6'h05, 0, 0, 0, 0, 0, 0, nr));
    dir_rows.push_back(mk(CMD_BUMP, 0, 0, 0, 0, 0, 0, 0, 0, nr));
    dir_rows.push_back(mk(CMD_ENQ, 8'h12, 6'h05, 0, 0, 0, 0, 0, 0, nr));
    dir_rows.push_back(mk(CMD_SVC, 0, 0, 0, 1, 0, 0, 0, 0, nr));          // abandon
    dir_rows.push_back(mk(CMD_ENQ, 8'h13, 6'h06, 0, 0, 0, 0, 0, 0, nr));
    dir_rows.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, nr));
    dir_rows.push_back(mk(3'd5, 8'hFF, 6'h3F, 8'hFF, 1, 2'd3, 1, 2'd3, 0, nr));
    dir_rows.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, nr));
    foreach (dir_rows[i]) begin
      issue_command(dir_rows[i].c);
      // typed rows give one result, the newest one the predictor queued
      if (dir_rows[i].has_exp && expected_results[$] !== dir_rows[i].r) begin
        $display("%0t: table row %0d, expected %h, actual %h", $time, i,
                 dir_rows[i].r, expected_results[$]);
        errors++;
      end
    end
    wait_quiet();

    // Full queue, then a reject, then multicast checking and passthrough.
    write_reg(REG_GLIMIT, 0);
    write_reg(REG_CHKMC, 1);
    for (int i = 0; i < 65; i++) begin
      c = random_command(); c.cmd = CMD_ENQ; issue_command(c);
    end
    c = random_command(); c.cmd = CMD_SVC; c.aband = 0; issue_command(c); // zero limit
    c = random_command(); c.cmd = CMD_DONE; c.st = ST_TIMEOUT; c.attr = ATTR_MULTI;
    issue_command(c);
    wait_quiet();
    write_reg(REG_GLIMIT, 1024);
    write_reg(REG_NLIMIT, 0);
    c = random_command(); c.cmd = CMD_SVC; c.aband = 0; issue_command(c);
    c.cmd = CMD_BUMP; issue_command(c);
    c.cmd = CMD_SVC; issue_command(c);                                     // all stale
    wait_quiet();
    write_reg(REG_QEN, 0);
    c = random_command(); c.cmd = CMD_ENQ; issue_command(c);
    wait_quiet();

    // Random phases over several register settings; the last one runs with
    // no idling, and the sender pauses for a full drain between phases.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_GLIMIT, ph == 0 ? 1 : ph == 1 ? 1024 : $urandom_range(2, 40));
      write_reg(REG_NLIMIT, ph == 0 ? 255 : ph == 1 ? 1 : $urandom_range(1, 6));
      write_reg(REG_QEN, 32'(ph != 3));
      write_reg(REG_CHKMC, 32'(ph[0]));
      idle_pct = (ph == 4) ? 0 : 26;
      for (int i = 0; i < 26; i++) issue_command(random_command());
      wait_quiet();
    end

    $display("Covered %0d commands, %0d results, %0d dispatches over five settings.",
             n_items, n_results, n_disp);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/crld_pkg.sv
rtl/crld_ctrl.sv
rtl/crld_dp.sv
rtl/credit_limited_request_dispatcher_top.sv
dv/testbench.sv
